>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the jitter buffer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/svjb_pkg.sv
// ----------------------------------------------------------------------------
// svjb_pkg
// Types, constants and helpers for the sequenced value jitter buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package svjb_pkg;

    localparam int MAX_ENTRIES = 30;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int SEQ_W       = 8;
    localparam int VAL_W       = 32;

    localparam logic [SEQ_W-1:0] BUFFER_DELAY_RST = 8'd3;
    localparam logic [SEQ_W-1:0] HALF_RANGE       = 8'd127;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_QUEUE = 2'd1,
        OP_SET   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP,
        S_APPLY,
        S_INS,
        S_DONE
    } t_state;

    // insert command broadcast to every cell
    typedef struct packed {
        logic             ins_en;
        logic [SEQ_W-1:0] seq;
        logic [VAL_W-1:0] value;
    } t_ins_cmd;

    // oldest held entry
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [VAL_W-1:0] value;
    } t_entry;

    // wrap-around recency: a is newer than b
    function automatic logic newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d_ab;
        logic [SEQ_W-1:0] d_ba;
        d_ab = a - b;
        d_ba = b - a;
        return ((a > b) && (d_ab <= HALF_RANGE)) || ((b > a) && (d_ba > HALF_RANGE));
    endfunction

endpackage

`default_nettype wire

>>> design/svjb_cell.sv
// ----------------------------------------------------------------------------
// svjb_cell
// One list slot: holds a (sequence, value) pair, takes the new item or its
// newer neighbor's entry on an insert.
// ----------------------------------------------------------------------------
`default_nettype none

module svjb_cell
    import svjb_pkg::*;
(
    input  wire              i_clk,
    input  t_ins_cmd         i_cmd,
    input  wire              i_occupied,
    input  wire              i_at_end,
    input  wire              i_found,
    input  wire [SEQ_W-1:0]  i_prev_seq,
    input  wire [VAL_W-1:0]  i_prev_value,
    output logic             o_found,
    output logic [SEQ_W-1:0] o_seq,
    output logic [VAL_W-1:0] o_value
);

    logic [SEQ_W-1:0] r_seq;
    logic [VAL_W-1:0] r_value;
    logic [SEQ_W-1:0] n_seq;
    logic [VAL_W-1:0] n_value;
    logic             stop;

    // insertion point is the first held entry that the new item is newer than
    assign stop    = i_occupied && newer(i_cmd.seq, r_seq);
    assign o_found = i_found || stop;

    always_comb begin
        n_seq   = r_seq;
        n_value = r_value;
        if (i_cmd.ins_en && (i_occupied || i_at_end)) begin
            if (i_found) begin
                n_seq   = i_prev_seq;
                n_value = i_prev_value;
            end else if (stop || i_at_end) begin
                n_seq   = i_cmd.seq;
                n_value = i_cmd.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq   <= n_seq;
        r_value <= n_value;
    end

    assign o_seq   = r_seq;
    assign o_value = r_value;

endmodule

`default_nettype wire

>>> design/svjb_chain.sv
// ----------------------------------------------------------------------------
// svjb_chain
// Row of list cells, newest at cell 0, with the oldest-entry select.
// ----------------------------------------------------------------------------
`default_nettype none

module svjb_chain
    import svjb_pkg::*;
(
    input  wire              i_clk,
    input  t_ins_cmd         i_cmd,
    input  wire [CNT_W-1:0]  i_count,
    output t_entry           o_oldest
);

    logic [MAX_ENTRIES:0]   found;
    logic [SEQ_W-1:0]       seq_a   [MAX_ENTRIES];
    logic [VAL_W-1:0]       value_a [MAX_ENTRIES];
    logic [CNT_W-1:0]       last;
    logic [IDX_W-1:0]       last_idx;

    assign found[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
            logic [SEQ_W-1:0] prev_seq;
            logic [VAL_W-1:0] prev_value;
            if (i == 0) begin : g_head
                assign prev_seq   = i_cmd.seq;
                assign prev_value = i_cmd.value;
            end else begin : g_body
                assign prev_seq   = seq_a[i-1];
                assign prev_value = value_a[i-1];
            end
            svjb_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (i_cmd),
                .i_occupied   (i_count > CNT_W'(i)),
                .i_at_end     (i_count == CNT_W'(i)),
                .i_found      (found[i]),
                .i_prev_seq   (prev_seq),
                .i_prev_value (prev_value),
                .o_found      (found[i+1]),
                .o_seq        (seq_a[i]),
                .o_value      (value_a[i])
            );
        end
    endgenerate

    // only looked at while the list holds at least one entry
    assign last           = i_count - CNT_W'(1);
    assign last_idx       = last[IDX_W-1:0];
    assign o_oldest.seq   = seq_a[last_idx];
    assign o_oldest.value = value_a[last_idx];

endmodule

`default_nettype wire

>>> design/sequenced_value_jitter_buffer_core.sv
// ----------------------------------------------------------------------------
// Sequenced value jitter buffer
// Sequence-numbered buffer of 32-bit values released on a ticking sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive opcode, sequence_req and value with start high
//   while busy is low; the item is taken at that edge (tick, queue, set
//   sequence, clear). Each item gives one result, shown for exactly one cycle
//   with o_result_valid; the receiver cannot stall, so the result must be
//   taken then. Result ports are only meaningful while the strobe is high.
//   Config channel: i_cfg_valid / o_cfg_ready write buffer_delay; ready is
//   high whenever busy is low.
//   From the accept edge, set and clear go straight to the done state;
//   queue passes the insert state; tick passes the drop state, which drops
//   up to 30 stale entries, and the apply state. The next item is taken
//   the cycle after the strobe. Stale entries are dropped one per cycle from
//   the oldest end of the cell row; inserts shift the whole row at once.
//   Reset empties the list, zeroes sequence, value and applied sequence and
//   sets buffer_delay to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module sequenced_value_jitter_buffer_core
    import svjb_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire [1:0]          i_opcode,
    input  wire [SEQ_W-1:0]    i_sequence_req,
    input  wire [VAL_W-1:0]    i_value,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire [SEQ_W-1:0]    i_cfg_data,
    output logic               o_result_valid,
    output logic [VAL_W-1:0]   o_applied_value,
    output logic               o_applied,
    output logic               o_accepted,
    output logic               o_overflow_cleared,
    output logic [4:0]         o_dropped_count,
    output logic [4:0]         o_occupancy,
    output logic [SEQ_W-1:0]   o_now_sequence,
    output logic [SEQ_W-1:0]   o_last_applied_sequence
);

    t_state           r_state,   n_state;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [CNT_W-1:0] r_dropped, n_dropped;
    logic [SEQ_W-1:0] r_cur,     n_cur;
    logic [VAL_W-1:0] r_cur_val, n_cur_val;
    logic [SEQ_W-1:0] r_app_seq, n_app_seq;
    logic [SEQ_W-1:0] r_delay,   n_delay;
    logic [SEQ_W-1:0] r_req,     n_req;
    logic [VAL_W-1:0] r_val,     n_val;
    logic             r_applied, n_applied;
    logic             r_accepted, n_accepted;
    logic             r_overflow, n_overflow;

    t_ins_cmd         ins_cmd;
    t_entry           oldest;
    logic             stale;
    logic [SEQ_W-1:0] oldest_next;

    svjb_chain u_chain (
        .i_clk    (i_clk),
        .i_cmd    (ins_cmd),
        .i_count  (r_count),
        .o_oldest (oldest)
    );

    // entry is stale once (seq + 1) is no longer newer than the current sequence
    assign oldest_next = oldest.seq + SEQ_W'(1);
    assign stale       = !newer(oldest_next, r_cur);

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_dropped      = r_dropped;
        n_cur          = r_cur;
        n_cur_val      = r_cur_val;
        n_app_seq      = r_app_seq;
        n_delay        = r_delay;
        n_req          = r_req;
        n_val          = r_val;
        n_applied      = r_applied;
        n_accepted     = r_accepted;
        n_overflow     = r_overflow;
        ins_cmd.ins_en = 1'b0;
        ins_cmd.seq    = r_req;
        ins_cmd.value  = r_val;
        o_result_valid = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_delay = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req      = i_sequence_req;
                    n_val      = i_value;
                    n_applied  = 1'b0;
                    n_accepted = 1'b0;
                    n_overflow = 1'b0;
                    n_dropped  = '0;
                    case (t_op'(i_opcode))
                        OP_TICK: begin
                            n_cur   = r_cur + SEQ_W'(1);
                            n_state = S_DROP;
                        end
                        OP_QUEUE: begin
                            n_state = S_INS;
                        end
                        OP_SET: begin
                            n_cur   = i_sequence_req - r_delay;
                            n_state = S_DONE;
                        end
                        OP_CLEAR: begin
                            n_count   = '0;
                            n_cur     = '0;
                            n_cur_val = '0;
                            n_app_seq = '0;
                            n_state   = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DROP: begin
                if ((r_count != '0) && stale) begin
                    n_count   = r_count - CNT_W'(1);
                    n_dropped = r_dropped + CNT_W'(1);
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if ((r_count != '0) && (oldest.seq == r_cur)) begin
                    n_cur_val = oldest.value;
                    n_count   = r_count - CNT_W'(1);
                    n_app_seq = r_cur;
                    n_applied = 1'b1;
                end
                n_state = S_DONE;
            end
            S_INS: begin
                if (newer(r_req, r_cur)) begin
                    n_accepted = 1'b1;
                    if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                        n_count    = '0;
                        n_overflow = 1'b1;
                    end else begin
                        ins_cmd.ins_en = 1'b1;
                        n_count        = r_count + CNT_W'(1);
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                o_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_dropped  <= '0;
            r_cur      <= '0;
            r_cur_val  <= '0;
            r_app_seq  <= '0;
            r_delay    <= BUFFER_DELAY_RST;
            r_applied  <= 1'b0;
            r_accepted <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_dropped  <= n_dropped;
            r_cur      <= n_cur;
            r_cur_val  <= n_cur_val;
            r_app_seq  <= n_app_seq;
            r_delay    <= n_delay;
            r_applied  <= n_applied;
            r_accepted <= n_accepted;
            r_overflow <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_val <= n_val;
    end

    assign o_applied_value         = r_cur_val;
    assign o_applied               = r_applied;
    assign o_accepted              = r_accepted;
    assign o_overflow_cleared      = r_overflow;
    assign o_dropped_count         = 5'(r_dropped);
    assign o_occupancy             = 5'(r_count);
    assign o_now_sequence          = r_cur;
    assign o_last_applied_sequence = r_app_seq;

endmodule

`default_nettype wire

>>> design/svjb_checker.sv
// ----------------------------------------------------------------------------
// svjb_checker
// Port-level checks on the jitter buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module svjb_checker
    import svjb_pkg::*;
(
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             start,
    input wire             busy,
    input wire             o_result_valid,
    input wire             o_applied,
    input wire             o_accepted,
    input wire             o_overflow_cleared,
    input wire [4:0]       o_occupancy,
    input wire [SEQ_W-1:0] o_now_sequence,
    input wire [SEQ_W-1:0] o_last_applied_sequence
);

    // a result only appears while an item is in flight
    `ASSERT_IMPL(a_strobe_busy, i_clk, i_rst_n, o_result_valid, busy)

    // a taken item keeps the block busy on the next cycle
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)

    // tick and queue flags never mix in one result
    `ASSERT_IMPL(a_flag_mix, i_clk, i_rst_n, o_result_valid, !(o_applied && o_accepted))

    // an overflow empties the list and still counts as accepted
    `ASSERT_IMPL(a_overflow, i_clk, i_rst_n, o_result_valid && o_overflow_cleared,
        (o_occupancy == 5'd0) && o_accepted)

    // an applied value is stamped with the current sequence
    `ASSERT_IMPL(a_applied_seq, i_clk, i_rst_n, o_result_valid && o_applied,
        o_last_applied_sequence == o_now_sequence)

endmodule

bind sequenced_value_jitter_buffer_core svjb_checker u_svjb_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .start                   (start),
    .busy                    (busy),
    .o_result_valid          (o_result_valid),
    .o_applied               (o_applied),
    .o_accepted              (o_accepted),
    .o_overflow_cleared      (o_overflow_cleared),
    .o_occupancy             (o_occupancy),
    .o_now_sequence          (o_now_sequence),
    .o_last_applied_sequence (o_last_applied_sequence)
);

`default_nettype wire
